>>> rtl/slm_pkg.sv
package slm_pkg;

  // Field widths
  localparam int unsigned LEVEL_W    = 14;
  localparam int unsigned RAW_W      = 10;
  localparam int unsigned NOISE_W    = 4;
  localparam int unsigned CAT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Default sizes
  localparam int unsigned WINDOW_DEF  = 10;
  localparam int unsigned LOG_CAP_DEF = 256;

  // Register reset values, hundredths of magnitude
  localparam logic [LEVEL_W-1:0] SIG_RST  = 14'd5000;
  localparam logic [LEVEL_W-1:0] MOD_RST  = 14'd5000;
  localparam logic [LEVEL_W-1:0] SEV_RST  = 14'd7500;
  localparam logic [LEVEL_W-1:0] WARN_RST = 14'd8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNIFICANCE = 4'd0,
    REG_MODERATE     = 4'd1,
    REG_SEVERE       = 4'd2,
    REG_WARNING      = 4'd3
  } cfg_reg_e;

  typedef enum logic [CAT_W-1:0] {
    CAT_MILD     = 2'd0,
    CAT_MODERATE = 2'd1,
    CAT_SEVERE   = 2'd2
  } cat_e;

endpackage

>>> rtl/slm_if.sv
// Sample channel
interface slm_in_if import slm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   raw_tenths;
  logic [NOISE_W-1:0] noise_hundredths;

  modport source (output valid, output raw_tenths, output noise_hundredths, input ready);
  modport sink   (input valid, input raw_tenths, input noise_hundredths, output ready);
endinterface

// Result channel
interface slm_out_if import slm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CAT_W-1:0]   category;
  logic [LEVEL_W-1:0] predicted_level;
  logic [LEVEL_W-1:0] risk_level;
  logic               risk_warning;
  logic               prediction_warning;
  logic               was_logged;
  logic               log_full;

  modport source (output valid, output category, output predicted_level, output risk_level,
                  output risk_warning, output prediction_warning, output was_logged,
                  output log_full, input ready);
  modport sink   (input valid, input category, input predicted_level, input risk_level,
                  input risk_warning, input prediction_warning, input was_logged,
                  input log_full, output ready);
endinterface

// Register write channel
interface slm_cfg_if import slm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/slm_ram.sv
// Simple dual-port RAM, one write and one registered read port
module slm_ram import slm_pkg::*; #(
  parameter int unsigned WIDTH = LEVEL_W,
  parameter int unsigned DEPTH = WINDOW_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/slm_div.sv
// Restoring divider, one quotient bit per cycle.
// done_o rises once the last quotient bit is in and holds until the next start.
module slm_div import slm_pkg::*; #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o,
  output logic             done_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot_q, quot_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic              fits;

  // One shift-subtract step
  always_comb begin
    rem_sh   = {rem_q, quot_q[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_q};
    fits     = (rem_sh >= {1'b0, den_q});

    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;

    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> rtl/seismic_level_monitor.sv
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+------------------------------------------
// cfg_i    | in  | valid/ready, ready=1  | index, data (low 14 bits kept)
// samp_i   | in  | valid/ready           | raw_tenths, noise_hundredths
// res_o    | out | valid/ready           | category, predicted/risk level, flags
//
// One item passes these steps from accept to the next accept: accept with window RAM
// read, read-modify-write of the window entry, the serial risk divider running one bit
// per cycle, a step to see it done, then the result load, which waits while the output
// register holds a stalled result. Reset sets all registers at once, the thresholds to
// their reset values; window entries read as zero until the pointer first wraps, so no
// clearing pass is needed. A stalled result sits in the output register while the next
// item is accepted; the following one waits there for it.
module seismic_level_monitor import slm_pkg::*; #(
  parameter int unsigned WINDOW       = WINDOW_DEF,
  parameter int unsigned LOG_CAPACITY = LOG_CAP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slm_cfg_if.sink   cfg_i,
  slm_in_if.sink    samp_i,
  slm_out_if.source res_o
);

  localparam int unsigned PTR_W     = $clog2(WINDOW);
  localparam int unsigned WT_W      = LEVEL_W + $clog2(WINDOW);
  localparam int unsigned CNT_W     = $clog2(LOG_CAPACITY + 1);
  localparam int unsigned LT_W      = LEVEL_W + CNT_W;
  localparam int unsigned DIV_NUM_W = LT_W;
  localparam int unsigned DIV_DEN_W = CNT_W;

  // Window mean by reciprocal: floor(x / WINDOW) = (x * RECIP_M) >> RECIP_SH,
  // exact for every WT_W-bit x
  localparam int unsigned     RECIP_SH = WT_W + $clog2(WINDOW);
  localparam int unsigned     RECIP_W  = WT_W + 2;
  localparam int unsigned     PROD_W   = WT_W + RECIP_W;
  localparam longint unsigned RECIP_M  =
    ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PUSH
  } state_e;

  // Configuration registers
  logic [LEVEL_W-1:0] sig_q, sig_d;
  logic [LEVEL_W-1:0] mod_q, mod_d;
  logic [LEVEL_W-1:0] sev_q, sev_d;
  logic [LEVEL_W-1:0] warn_q, warn_d;

  // Running state
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic               wrapped_q, wrapped_d;
  logic [WT_W-1:0]    wtot_q, wtot_d;
  logic [LT_W-1:0]    ltot_q, ltot_d;
  logic [CNT_W-1:0]   lcnt_q, lcnt_d;

  // Item in flight
  state_e             state_q, state_d;
  logic [LEVEL_W-1:0] noisy_q, noisy_d;
  cat_e               cat_q, cat_d;
  logic               logged_q, logged_d;
  logic               full_q, full_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [CAT_W-1:0]   out_cat_q, out_cat_d;
  logic [LEVEL_W-1:0] out_pred_q, out_pred_d;
  logic [LEVEL_W-1:0] out_risk_q, out_risk_d;
  logic               out_rwarn_q, out_rwarn_d;
  logic               out_pwarn_q, out_pwarn_d;
  logic               out_logged_q, out_logged_d;
  logic               out_full_q, out_full_d;

  // Datapath
  logic               samp_acc;
  logic [LEVEL_W-1:0] raw_h;
  logic [LEVEL_W-1:0] noisy_in;
  logic [LEVEL_W-1:0] ram_rdata;
  logic [LEVEL_W-1:0] old_val;
  logic               ram_we;
  logic               div_start;
  logic               slot_free;

  logic [PROD_W-1:0]    pred_prod;
  logic [WT_W-1:0]      warn_win;
  logic [DIV_NUM_W-1:0] rq;
  logic [DIV_DEN_W-1:0] rrem;
  logic                 rdone;
  logic [DIV_NUM_W-1:0] warn_ext;

  assign samp_acc     = samp_i.valid && samp_i.ready;
  assign samp_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign slot_free    = !out_valid_q || res_o.ready;

  // raw * 10 as two shifts, then the noise term
  assign raw_h    = (LEVEL_W'(samp_i.raw_tenths) << 3) + (LEVEL_W'(samp_i.raw_tenths) << 1);
  assign noisy_in = raw_h + LEVEL_W'(samp_i.noise_hundredths);

  // Entry at the pointer holds data only once the pointer has wrapped
  assign old_val   = wrapped_q ? ram_rdata : '0;
  assign ram_we    = (state_q == ST_READ);
  assign div_start = (state_q == ST_READ);
  assign warn_ext  = DIV_NUM_W'(warn_q);

  // Window mean from the registered window total, and the warning level scaled to a window total
  assign pred_prod = PROD_W'(wtot_q) * PROD_W'(RECIP_M);
  assign warn_win  = WT_W'(warn_q) * WT_W'(WINDOW);

  // Window store. The read of an item is issued at accept and its write in the next
  // cycle; the next item reads only after that, so no forwarding is needed.
  slm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (WINDOW)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (noisy_q),
    .re_i    (samp_acc),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Risk mean: logged total over logged count
  slm_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_risk_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DIV_NUM_W'(ltot_d)),
    .den_i   (DIV_DEN_W'(lcnt_d)),
    .quot_o  (rq),
    .rem_o   (rrem),
    .done_o  (rdone)
  );

  // Register writes
  always_comb begin
    sig_d  = sig_q;
    mod_d  = mod_q;
    sev_d  = sev_q;
    warn_d = warn_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SIGNIFICANCE: sig_d  = cfg_i.data[LEVEL_W-1:0];
        REG_MODERATE:     mod_d  = cfg_i.data[LEVEL_W-1:0];
        REG_SEVERE:       sev_d  = cfg_i.data[LEVEL_W-1:0];
        REG_WARNING:      warn_d = cfg_i.data[LEVEL_W-1:0];
        default:          ;
      endcase
    end
  end

  // Sequencer and state updates
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    wrapped_d    = wrapped_q;
    wtot_d       = wtot_q;
    ltot_d       = ltot_q;
    lcnt_d       = lcnt_q;
    noisy_d      = noisy_q;
    cat_d        = cat_q;
    logged_d     = logged_q;
    full_d       = full_q;
    out_valid_d  = out_valid_q;
    out_cat_d    = out_cat_q;
    out_pred_d   = out_pred_q;
    out_risk_d   = out_risk_q;
    out_rwarn_d  = out_rwarn_q;
    out_pwarn_d  = out_pwarn_q;
    out_logged_d = out_logged_q;
    out_full_d   = out_full_q;

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (samp_acc) begin
          noisy_d = noisy_in;
          // severe test wins when the levels cross
          if (raw_h >= sev_q) begin
            cat_d = CAT_SEVERE;
          end else if (raw_h >= mod_q) begin
            cat_d = CAT_MODERATE;
          end else begin
            cat_d = CAT_MILD;
          end
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // replace the oldest window entry
        wtot_d = wtot_q - WT_W'(old_val) + WT_W'(noisy_q);
        if (ptr_q == PTR_W'(WINDOW - 1)) begin
          ptr_d     = '0;
          wrapped_d = 1'b1;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
        // significant-sample log
        logged_d = 1'b0;
        full_d   = 1'b0;
        if (noisy_q > sig_q) begin
          if (lcnt_q < CNT_W'(LOG_CAPACITY)) begin
            ltot_d   = ltot_q + LT_W'(noisy_q);
            lcnt_d   = lcnt_q + CNT_W'(1);
            logged_d = 1'b1;
          end else begin
            full_d = 1'b1;
          end
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rdone) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_cat_d    = cat_q;
          out_pred_d   = pred_prod[RECIP_SH +: LEVEL_W];
          out_pwarn_d  = (wtot_q > warn_win);
          if (lcnt_q == '0) begin
            out_risk_d  = '0;
            out_rwarn_d = 1'b0;
          end else begin
            // mean above the level: quotient above it, or equal with a remainder
            out_risk_d  = rq[LEVEL_W-1:0];
            out_rwarn_d = (rq > warn_ext) || ((rq == warn_ext) && (rrem != '0));
          end
          out_logged_d = logged_q;
          out_full_d   = full_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q        <= SIG_RST;
      mod_q        <= MOD_RST;
      sev_q        <= SEV_RST;
      warn_q       <= WARN_RST;
      state_q      <= ST_IDLE;
      ptr_q        <= '0;
      wrapped_q    <= 1'b0;
      wtot_q       <= '0;
      ltot_q       <= '0;
      lcnt_q       <= '0;
      noisy_q      <= '0;
      cat_q        <= CAT_MILD;
      logged_q     <= 1'b0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cat_q    <= '0;
      out_pred_q   <= '0;
      out_risk_q   <= '0;
      out_rwarn_q  <= 1'b0;
      out_pwarn_q  <= 1'b0;
      out_logged_q <= 1'b0;
      out_full_q   <= 1'b0;
    end else begin
      sig_q        <= sig_d;
      mod_q        <= mod_d;
      sev_q        <= sev_d;
      warn_q       <= warn_d;
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      wrapped_q    <= wrapped_d;
      wtot_q       <= wtot_d;
      ltot_q       <= ltot_d;
      lcnt_q       <= lcnt_d;
      noisy_q      <= noisy_d;
      cat_q        <= cat_d;
      logged_q     <= logged_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
      out_cat_q    <= out_cat_d;
      out_pred_q   <= out_pred_d;
      out_risk_q   <= out_risk_d;
      out_rwarn_q  <= out_rwarn_d;
      out_pwarn_q  <= out_pwarn_d;
      out_logged_q <= out_logged_d;
      out_full_q   <= out_full_d;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.category           = out_cat_q;
  assign res_o.predicted_level    = out_pred_q;
  assign res_o.risk_level         = out_risk_q;
  assign res_o.risk_warning       = out_rwarn_q;
  assign res_o.prediction_warning = out_pwarn_q;
  assign res_o.was_logged         = out_logged_q;
  assign res_o.log_full           = out_full_q;

endmodule

>>> rtl/slm_chk.sv
// Port-level checks for the level monitor
module slm_chk import slm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_valid_i,
  input logic               s_ready_i,
  input logic               r_valid_i,
  input logic               r_ready_i,
  input logic [LEVEL_W-1:0] r_risk_i,
  input logic               r_risk_warn_i,
  input logic               r_logged_i,
  input logic               r_full_i
);

  // items accepted but not yet delivered
  logic [1:0] pend_q, pend_d;

  always_comb begin
    pend_d = pend_q;
    if ((s_valid_i && s_ready_i) && !(r_valid_i && r_ready_i)) begin
      pend_d = pend_q + 2'd1;
    end else if (!(s_valid_i && s_ready_i) && (r_valid_i && r_ready_i)) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && !r_ready_i |=> r_valid_i && $stable(r_risk_i))
    else $error("result changed while stalled");

  // at most one item in work plus one waiting result
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

  // no result without an item behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i |-> pend_q != 2'd0)
    else $error("result without accepted item");

  // a sample is never both logged and dropped
  a_log_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i |-> !(r_logged_i && r_full_i))
    else $error("logged and dropped at once");

  // logged samples are at least one, so a zero risk means an empty log
  a_risk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && (r_risk_i == '0) |-> !r_risk_warn_i)
    else $error("risk warning with zero risk");

endmodule

bind seismic_level_monitor slm_chk u_slm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_valid_i     (samp_i.valid),
  .s_ready_i     (samp_i.ready),
  .r_valid_i     (res_o.valid),
  .r_ready_i     (res_o.ready),
  .r_risk_i      (res_o.risk_level),
  .r_risk_warn_i (res_o.risk_warning),
  .r_logged_i    (res_o.was_logged),
  .r_full_i      (res_o.log_full)
);
